// File: hdl/sqspw_pkg.sv
// shared types, constants and helper functions for the square spiral waypoint generator
package sqspw_pkg;

	localparam int POS_WIDTH = 16;
	localparam int LEG_WIDTH = 12;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 3;

	typedef enum logic [2:0] {
		HD_E  = 3'd0,
		HD_NE = 3'd1,
		HD_N  = 3'd2,
		HD_NW = 3'd3,
		HD_W  = 3'd4,
		HD_SW = 3'd5,
		HD_S  = 3'd6,
		HD_SE = 3'd7
	} heading_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_WALKER_MODE   = 2'd0,
		CFG_START_HEADING = 2'd1,
		CFG_SPARE_2       = 2'd2,
		CFG_SPARE_3       = 2'd3
	} cfg_index_t;

	localparam heading_t RESET_HEADING = HD_N;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] x;
		logic signed [POS_WIDTH-1:0] y;
		heading_t                    dir;
		logic [LEG_WIDTH-1:0]        steps;
		logic [LEG_WIDTH-1:0]        leg;
		logic                        grow2;
		logic                        start;
	} walk_state_t;

	localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

	// cardinal turns a quarter ccw, diagonal snaps forward to its cardinal
	function automatic heading_t turn_dir(input heading_t d);
		logic [2:0] inc;
		inc = d[0] ? 3'd1 : 3'd2;
		return heading_t'(3'(d + inc));
	endfunction

	function automatic logic x_up(input heading_t d);
		return (d == HD_E) || (d == HD_NE) || (d == HD_SE);
	endfunction

	function automatic logic x_down(input heading_t d);
		return (d == HD_NW) || (d == HD_W) || (d == HD_SW);
	endfunction

	function automatic logic y_up(input heading_t d);
		return (d == HD_NE) || (d == HD_N) || (d == HD_NW);
	endfunction

	function automatic logic y_down(input heading_t d);
		return (d == HD_SW) || (d == HD_S) || (d == HD_SE);
	endfunction

	// saturating move by one grid step
	function automatic logic signed [POS_WIDTH-1:0] pos_move(
		input logic signed [POS_WIDTH-1:0] p,
		input logic up,
		input logic down
	);
		logic signed [POS_WIDTH-1:0] r;
		r = p;
		if (up && (p != POS_MAX)) begin
			r = p + POS_WIDTH'(1);
		end else if (down && (p != POS_MIN)) begin
			r = p - POS_WIDTH'(1);
		end
		return r;
	endfunction

	// saturating leg length growth
	function automatic logic [LEG_WIDTH-1:0] leg_add(
		input logic [LEG_WIDTH-1:0] leg,
		input logic [2:0] inc
	);
		logic [LEG_WIDTH:0] sum;
		sum = {1'b0, leg} + (LEG_WIDTH+1)'(inc);
		return sum[LEG_WIDTH] ? {LEG_WIDTH{1'b1}} : sum[LEG_WIDTH-1:0];
	endfunction

endpackage

// File: hdl/sqspw_step.sv
// next walk state for one request: restart, three-walker or six-walker step
module sqspw_step (
	input  sqspw_pkg::walk_state_t cur,
	input  logic                   walker_mode,
	input  sqspw_pkg::heading_t    start_heading,
	input  logic                   restart,
	output sqspw_pkg::walk_state_t nxt
);

	logic [sqspw_pkg::LEG_WIDTH-1:0] steps_c;
	logic                            done2;
	logic                            done_leg;
	sqspw_pkg::heading_t             dir_t;

	assign steps_c  = (cur.steps == {sqspw_pkg::LEG_WIDTH{1'b1}}) ? cur.steps
		: cur.steps + sqspw_pkg::LEG_WIDTH'(1);
	assign done2    = steps_c >= sqspw_pkg::LEG_WIDTH'(2);
	assign done_leg = steps_c >= cur.leg;
	assign dir_t    = sqspw_pkg::turn_dir(cur.dir);

	always_comb begin
		nxt = cur;
		if (restart) begin
			nxt.x     = '0;
			nxt.y     = '0;
			nxt.dir   = start_heading;
			nxt.steps = '0;
			nxt.leg   = sqspw_pkg::LEG_WIDTH'(1);
			nxt.grow2 = 1'b1;
			nxt.start = 1'b1;
		end else begin
			nxt.x = sqspw_pkg::pos_move(cur.x, sqspw_pkg::x_up(cur.dir),
				sqspw_pkg::x_down(cur.dir));
			nxt.y = sqspw_pkg::pos_move(cur.y, sqspw_pkg::y_up(cur.dir),
				sqspw_pkg::y_down(cur.dir));
			if (!walker_mode) begin
				if (cur.start) begin
					case (cur.dir)
						sqspw_pkg::HD_NE: begin
							nxt.dir   = sqspw_pkg::HD_W;
							nxt.steps = '0;
							nxt.leg   = sqspw_pkg::LEG_WIDTH'(2);
							nxt.start = 1'b0;
							nxt.grow2 = 1'b0;
						end
						sqspw_pkg::HD_E: begin
							nxt.steps = steps_c;
							if (done2) begin
								nxt.dir   = dir_t;
								nxt.steps = '0;
								nxt.leg   = sqspw_pkg::LEG_WIDTH'(2);
								nxt.start = 1'b0;
							end
						end
						default: begin
							nxt.dir   = dir_t;
							nxt.steps = '0;
							nxt.leg   = sqspw_pkg::LEG_WIDTH'(3);
							nxt.start = 1'b0;
							nxt.grow2 = 1'b0;
						end
					endcase
				end else begin
					nxt.steps = steps_c;
					if (done_leg) begin
						nxt.steps = '0;
						nxt.leg   = sqspw_pkg::leg_add(cur.leg, cur.grow2 ? 3'd2 : 3'd1);
						nxt.grow2 = !cur.grow2;
						nxt.dir   = dir_t;
					end
				end
			end else begin
				// regular six-walker leg, also used for start headings without a start rule
				nxt.steps = steps_c;
				if (done_leg) begin
					nxt.dir   = dir_t;
					nxt.steps = '0;
					nxt.leg   = sqspw_pkg::leg_add(cur.leg, 3'd3);
				end
				if (cur.start) begin
					case (cur.dir) inside
						sqspw_pkg::HD_W, sqspw_pkg::HD_N, sqspw_pkg::HD_NE,
						sqspw_pkg::HD_SE: begin
							nxt.dir   = dir_t;
							nxt.steps = '0;
							nxt.start = 1'b0;
							nxt.leg   = (cur.dir == sqspw_pkg::HD_W)  ? sqspw_pkg::LEG_WIDTH'(3)
								: (cur.dir == sqspw_pkg::HD_NE) ? sqspw_pkg::LEG_WIDTH'(1)
								: sqspw_pkg::LEG_WIDTH'(2);
						end
						sqspw_pkg::HD_E, sqspw_pkg::HD_S: begin
							nxt.dir   = cur.dir;
							nxt.steps = steps_c;
							nxt.leg   = cur.leg;
							if (done2) begin
								nxt.dir   = dir_t;
								nxt.steps = '0;
								nxt.start = 1'b0;
								nxt.leg   = (cur.dir == sqspw_pkg::HD_E) ? sqspw_pkg::LEG_WIDTH'(3)
									: sqspw_pkg::LEG_WIDTH'(4);
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

// File: hdl/square_spiral_waypoint_generator_core.sv
// top level of the square spiral waypoint generator: state, config and result registers
//
// usage:
//   request channel (in_valid/in_ready, restart): each transfer either restarts the
//   walk from the configured start heading (restart=1) or advances it one grid step
//   (restart=0). every request produces exactly one result.
//   result channel (out_valid/out_ready, pos_x, pos_y, heading): new position in
//   grid steps and the heading after the request.
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   walker_mode, index 1 is start_heading; other indexes are ignored. cfg_ready is
//   always high. start_heading takes effect at the next restart.
// a result is registered at its request transfer and shows in the next cycle.
// throughput: one request per cycle unless the result stalls; the next-step logic is
//   a single pass between the walk state register and the result register.
// stall: a pending result holds while out_ready is low; in_ready then drops, and it
//   stays high when the pending result is taken in the same cycle.
// reset: walk at (0,0) heading north, three-walker mode, no result pending.
module square_spiral_waypoint_generator_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    restart,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [sqspw_pkg::POS_WIDTH-1:0]  pos_x,
	output logic signed [sqspw_pkg::POS_WIDTH-1:0]  pos_y,
	output logic [2:0]                              heading,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sqspw_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [sqspw_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	// walk state and configuration
	sqspw_pkg::walk_state_t walk_q;
	sqspw_pkg::walk_state_t walk_nxt;
	logic                   walker_mode_q;
	sqspw_pkg::heading_t    start_heading_q;

	// result register
	logic                                   out_valid_q;
	logic signed [sqspw_pkg::POS_WIDTH-1:0] pos_x_q;
	logic signed [sqspw_pkg::POS_WIDTH-1:0] pos_y_q;
	sqspw_pkg::heading_t                    heading_q;

	logic in_xfer;
	logic cfg_xfer;

	// take a request whenever the result slot is empty or being emptied
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	sqspw_step u_step (
		.cur           (walk_q),
		.walker_mode   (walker_mode_q),
		.start_heading (start_heading_q),
		.restart       (restart),
		.nxt           (walk_nxt)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_mode_q   <= 1'b0;
			start_heading_q <= sqspw_pkg::RESET_HEADING;
		end else if (cfg_xfer) begin
			unique case (sqspw_pkg::cfg_index_t'(cfg_index))
				sqspw_pkg::CFG_WALKER_MODE:   walker_mode_q   <= cfg_data[0];
				sqspw_pkg::CFG_START_HEADING: start_heading_q <= sqspw_pkg::heading_t'(cfg_data[2:0]);
				default: begin
				end
			endcase
		end
	end

	// walk state advances on every request transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.x     <= '0;
			walk_q.y     <= '0;
			walk_q.dir   <= sqspw_pkg::RESET_HEADING;
			walk_q.steps <= '0;
			walk_q.leg   <= sqspw_pkg::LEG_WIDTH'(1);
			walk_q.grow2 <= 1'b1;
			walk_q.start <= 1'b1;
		end else if (in_xfer) begin
			walk_q <= walk_nxt;
		end
	end

	// result register, cleared at reset so the shown position matches the walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= sqspw_pkg::RESET_HEADING;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
			pos_x_q     <= walk_nxt.x;
			pos_y_q     <= walk_nxt.y;
			heading_q   <= walk_nxt.dir;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;

endmodule

// File: hdl/sqspw_checker.sv
// port-level checks for the square spiral waypoint generator, bound to the top level
module sqspw_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    restart,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [sqspw_pkg::POS_WIDTH-1:0]  pos_x,
	input logic signed [sqspw_pkg::POS_WIDTH-1:0]  pos_y,
	input logic [2:0]                              heading
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(heading))
		else $error("result changed while stalled");

	// every request transfer yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after request");

	// a restart returns to the origin
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && restart |=> pos_x == '0 && pos_y == '0)
		else $error("restart did not return to origin");

	// a step moves each axis by at most one grid step
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !restart |=>
			(pos_x == $past(pos_x) || pos_x == $past(pos_x) + sqspw_pkg::POS_WIDTH'(1)
				|| pos_x == $past(pos_x) - sqspw_pkg::POS_WIDTH'(1))
			&& (pos_y == $past(pos_y) || pos_y == $past(pos_y) + sqspw_pkg::POS_WIDTH'(1)
				|| pos_y == $past(pos_y) - sqspw_pkg::POS_WIDTH'(1)))
		else $error("step moved more than one grid step");

endmodule

bind square_spiral_waypoint_generator_core sqspw_checker u_sqspw_checker (.*);

// File: verif/tb_top.sv
// self-checking testbench for the square spiral waypoint generator core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sqspw_pkg::*;

	// saturation bounds of the walk, at the block's widths
	localparam int POS_HI  = 2 ** (POS_WIDTH - 1) - 1;
	localparam int POS_LO  = -(2 ** (POS_WIDTH - 1));
	localparam int LEG_TOP = 2 ** LEG_WIDTH - 1;

	// one predicted result transfer
	typedef struct {
		logic signed [POS_WIDTH-1:0] x;
		logic signed [POS_WIDTH-1:0] y;
		heading_t                    dir;
	} waypoint_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic                        restart   = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_y;
	logic [2:0]                  heading;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

	// walk state and register copies kept by the predictor
	logic signed [POS_WIDTH-1:0] walk_x;
	logic signed [POS_WIDTH-1:0] walk_y;
	heading_t                    walk_dir;
	logic [LEG_WIDTH-1:0]        leg_steps;
	logic [LEG_WIDTH-1:0]        leg_len;
	bit                          grow_two;
	bit                          start_phase;
	bit                          cfg_mode;
	heading_t                    cfg_heading;

	// pending requests, and waypoints still owed by the block
	bit        request_q[$];
	waypoint_t waypoint_q[$];
	int        requests_open = 0;

	// idling controls, set per phase by the stimulus
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int tx_gap  = 0;
	int rx_stall = 0;

	// long receiver hold-off, run by its own process
	bit rx_hold   = 1'b0;
	int hold_req  = 0;
	int hold_done = 0;

	int error_cnt = 0;

	square_spiral_waypoint_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.heading   (heading),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// generous overall limit: about 720 requests, worst gaps and stalls, two holds
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_error(input string msg);
		error_cnt++;
		if (error_cnt <= 100) begin
			$display("[%0t] error: %s", $time, msg);
		end
	endtask

	// ---------------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------------

	function automatic logic signed [POS_WIDTH-1:0] clamp_pos(input int v);
		if (v > POS_HI) begin
			return POS_WIDTH'(POS_HI);
		end
		if (v < POS_LO) begin
			return POS_WIDTH'(POS_LO);
		end
		return POS_WIDTH'(v);
	endfunction

	function automatic logic [LEG_WIDTH-1:0] clamp_leg(input int v);
		return (v > LEG_TOP) ? LEG_WIDTH'(LEG_TOP) : LEG_WIDTH'(v);
	endfunction

	// cardinal headings turn a quarter ccw, diagonals snap forward to a cardinal
	function automatic heading_t next_leg_dir(input heading_t d);
		logic [2:0] s;
		s = d + (d[0] ? 3'd1 : 3'd2);
		return heading_t'(s);
	endfunction

	// restart: origin, configured heading, first leg of one step
	function automatic void reload_walk();
		walk_x      = '0;
		walk_y      = '0;
		walk_dir    = cfg_heading;
		leg_steps   = '0;
		leg_len     = LEG_WIDTH'(1);
		grow_two    = 1'b1;
		start_phase = 1'b1;
	endfunction

	function automatic void count_step();
		leg_steps = clamp_leg(int'(leg_steps) + 1);
	endfunction

	function automatic void begin_leg(input int len);
		leg_steps   = '0;
		leg_len     = clamp_leg(len);
		start_phase = 1'b0;
	endfunction

	// next waypoint for one accepted request
	function automatic waypoint_t advance_walk(input bit rst);
		int        dx;
		int        dy;
		int        len;
		bit        handled;
		waypoint_t wp;
		if (rst) begin
			reload_walk();
		end else begin
			case (walk_dir)
				HD_E:    begin dx =  1; dy =  0; end
				HD_NE:   begin dx =  1; dy =  1; end
				HD_N:    begin dx =  0; dy =  1; end
				HD_NW:   begin dx = -1; dy =  1; end
				HD_W:    begin dx = -1; dy =  0; end
				HD_SW:   begin dx = -1; dy = -1; end
				HD_S:    begin dx =  0; dy = -1; end
				default: begin dx =  1; dy = -1; end
			endcase
			walk_x = clamp_pos(int'(walk_x) + dx);
			walk_y = clamp_pos(int'(walk_y) + dy);
			handled = 1'b0;
			if (start_phase && !cfg_mode) begin
				// three-walker opening: every heading has a start rule
				handled = 1'b1;
				if (walk_dir == HD_NE) begin
					walk_dir = HD_W;
					begin_leg(2);
					grow_two = 1'b0;
				end else if (walk_dir == HD_E) begin
					count_step();
					if (leg_steps >= LEG_WIDTH'(2)) begin
						walk_dir = next_leg_dir(walk_dir);
						begin_leg(2);
					end
				end else begin
					walk_dir = next_leg_dir(walk_dir);
					begin_leg(3);
					grow_two = 1'b0;
				end
			end else if (start_phase) begin
				// six-walker opening
				handled = 1'b1;
				case (walk_dir)
					HD_W: begin
						walk_dir = next_leg_dir(walk_dir);
						begin_leg(3);
					end
					HD_N, HD_SE: begin
						walk_dir = next_leg_dir(walk_dir);
						begin_leg(2);
					end
					HD_NE: begin
						walk_dir = next_leg_dir(walk_dir);
						begin_leg(1);
					end
					HD_E, HD_S: begin
						len = (walk_dir == HD_E) ? 3 : 4;
						count_step();
						if (leg_steps >= LEG_WIDTH'(2)) begin
							walk_dir = next_leg_dir(walk_dir);
							begin_leg(len);
						end
					end
					default: begin
						// northwest and southwest: regular rule, opening stays active
						handled = 1'b0;
					end
				endcase
			end
			if (!handled) begin
				count_step();
				if (leg_steps >= leg_len) begin
					leg_steps = '0;
					if (cfg_mode) begin
						leg_len = clamp_leg(int'(leg_len) + 3);
					end else begin
						leg_len  = clamp_leg(int'(leg_len) + (grow_two ? 2 : 1));
						grow_two = !grow_two;
					end
					walk_dir = next_leg_dir(walk_dir);
				end
			end
		end
		wp.x   = walk_x;
		wp.y   = walk_y;
		wp.dir = walk_dir;
		return wp;
	endfunction

	// ---------------------------------------------------------------------------
	// idling: mostly short gaps, now and then a long one
	// ---------------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------------------
	// request driver
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		bit        nv;
		bit        nr;
		waypoint_t wp;
		nv = in_valid;
		nr = restart;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			// transfer at this edge: predict its waypoint right away
			if (in_valid && in_ready) begin
				wp = advance_walk(restart);
				waypoint_q.push_back(wp);
				requests_open--;
				nv = 1'b0;
			end
			// valid stays up until its transfer; only then may a gap or a new item follow
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (request_q.size() > 0) begin
					nr = request_q.pop_front();
					nv = 1'b1;
					if (tx_gaps) begin
						tx_gap = pick_gap();
					end
				end
			end
		end
		in_valid <= nv;
		restart  <= nr;
	end

	// ---------------------------------------------------------------------------
	// result monitor
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		bit        nr;
		waypoint_t want;
		nr = out_ready;
		if (!arst_n) begin
			nr = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (waypoint_q.size() == 0) begin
					report_error($sformatf("result (%0d,%0d) heading %0d with nothing pending",
						pos_x, pos_y, heading));
				end else begin
					want = waypoint_q.pop_front();
					if (pos_x !== want.x) begin
						report_error($sformatf("pos_x got %0d, want %0d", pos_x, want.x));
					end
					if (pos_y !== want.y) begin
						report_error($sformatf("pos_y got %0d, want %0d", pos_y, want.y));
					end
					if (heading !== want.dir) begin
						report_error($sformatf("heading got %0d, want %0d", heading, want.dir));
					end
				end
			end
			// the long hold-off wins over the random stalls
			if (rx_hold) begin
				nr = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
				if (rx_gaps && ($urandom_range(0, 2) == 0)) begin
					rx_stall = pick_gap();
				end
			end
		end
		out_ready <= nr;
	end

	// long receiver hold-off while the sender keeps offering, so the input stalls
	initial begin
		forever begin
			@(posedge clk);
			if (hold_done != hold_req) begin
				rx_hold <= 1'b1;
				repeat (80) @(posedge clk);
				rx_hold <= 1'b0;
				hold_done++;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------

	// register write; only called while nothing is in flight
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WALKER_MODE:   cfg_mode = data[0];
			CFG_START_HEADING: cfg_heading = heading_t'(data);
			default: ;
		endcase
	endtask

	task automatic push_request(input bit rst);
		request_q.push_back(rst);
		requests_open++;
	endtask

	task automatic push_steps(input int n);
		for (int i = 0; i < n; i++) begin
			push_request(1'b0);
		end
	endtask

	// one walk: usually a leading restart, then mostly steps
	task automatic queue_walk(input int n, input int restart_pct);
		if ($urandom_range(0, 3) != 0) begin
			push_request(1'b1);
		end
		for (int i = 0; i < n; i++) begin
			push_request($urandom_range(0, 99) < restart_pct);
		end
	endtask

	// sender pause: wait until every request went in and every result came out
	task automatic settle();
		int guard;
		guard = 0;
		while ((requests_open != 0 || waypoint_q.size() != 0 || hold_done != hold_req)
			&& guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 20000) begin
			report_error("traffic did not drain");
		end
	endtask

	initial begin
		bit mode_sel;
		int hd;
		cfg_mode    = 1'b0;
		cfg_heading = RESET_HEADING;
		reload_walk();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: walk from the reset state, then a restart and a short walk
		push_steps(10);
		push_request(1'b1);
		push_steps(3);
		settle();

		// a new start heading stays off the walk until the next restart;
		// east is taken as given, not remapped
		write_reg(CFG_START_HEADING, HD_E);
		push_steps(2);
		push_request(1'b1);
		push_steps(4);
		settle();

		// writes to unused indexes change nothing
		write_reg(CFG_SPARE_2, 3'b111);
		write_reg(CFG_SPARE_3, 3'b000);
		push_steps(2);
		settle();

		// random walks: every start heading in both modes, then random settings
		for (int ph = 0; ph < 20; ph++) begin
			if (ph < 16) begin
				mode_sel = (ph >= 8);
				hd       = ph % 8;
			end else begin
				mode_sel = 1'($urandom_range(0, 1));
				hd       = $urandom_range(0, 7);
			end
			// upper data bits of the mode write are don't-care
			write_reg(CFG_WALKER_MODE, {2'($urandom), mode_sel});
			write_reg(CFG_START_HEADING, 3'(hd));
			if ($urandom_range(0, 3) == 0) begin
				write_reg(cfg_index_t'($urandom_range(2, 3)), 3'($urandom));
			end
			// every fourth phase runs without idling on either side
			tx_gaps = (ph % 4 != 3);
			rx_gaps = (ph % 4 != 3);
			if (ph == 5 || ph == 13) begin
				tx_gaps = 1'b0;
				hold_req++;
			end
			// some phases walk on without further restarts to reach longer legs
			queue_walk($urandom_range(25, 45), (ph % 5 == 4) ? 0 : 5);
			settle();
		end

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		settle();
		repeat (5) @(posedge clk);
		if (waypoint_q.size() != 0) begin
			report_error($sformatf("%0d waypoints never came out", waypoint_q.size()));
		end
		if (error_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
